### rtl/wavetable_resampling_oscillator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable resampling oscillator
// Shared implication checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_RESAMPLING_OSCILLATOR_TOP_DEFINES_SVH
`define WAVETABLE_RESAMPLING_OSCILLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define WRO_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("wro: same-cycle check failed");

// next-cycle implication
`define WRO_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("wro: next-cycle check failed");

`endif

### rtl/wro_pkg.sv
// ----------------------------------------------------------------------------
// wro_pkg
// Shared constants, codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package wro_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_RING_DEF    = 1024;

	localparam int SAMPLE_W    = 16;
	localparam int LOAD_IDX_W  = 8;
	localparam int RING_LEN_W  = 11;
	localparam int MODEL_LEN_W = 9;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int S_DATA_W    = 24;

	localparam logic [RING_LEN_W-1:0]  RING_LEN_RST  = 11'd200;
	localparam logic [MODEL_LEN_W-1:0] MODEL_LEN_RST = 9'd133;

	localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAT_NEG_MAG = 16'h8000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODEL_LENGTH = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_R,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_RD_A,
		ST_RD_B,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_r;
		logic div1_go;
		logic k_cap;
		logic rd_b;
		logic a_cap;
		logic mul_a;
		logic mul_b;
		logic sum;
		logic div2_go;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

### rtl/wro_ram.sv
// ----------------------------------------------------------------------------
// wro_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wro_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/wro_div.sv
// ----------------------------------------------------------------------------
// wro_div
// Restoring divider, one quotient bit per cycle, caller-aligned operands.
// ----------------------------------------------------------------------------
`include "wavetable_resampling_oscillator_top_defines.svh"

module wro_div #(
	parameter int DSW = 12,
	parameter int QW  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [$clog2(QW+1)-1:0]  iters,
	input  logic [DSW-1:0]           rem_init,
	input  logic [QW-1:0]            lo_init,
	input  logic [DSW-1:0]           divisor,
	output logic                     busy,
	output logic [QW-1:0]            quo,
	output logic [DSW-1:0]           rem
);

	localparam int CW = $clog2(QW+1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic [QW-1:0]  lo_q;
	logic [QW-1:0]  quo_q;

	logic [DSW:0] trial;
	logic [DSW:0] diff;
	logic         ge;

	assign trial = {rem_q, lo_q[QW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			lo_q  <= lo_init;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	`WRO_ASSERT_NXT(a_div_count, clk, arst_n, start, busy_q && cnt_q == $past(iters))

endmodule

### rtl/wro_dp.sv
// ----------------------------------------------------------------------------
// wro_dp
// Oscillator datapath: config, ring position, table, multiplies, divider.
// ----------------------------------------------------------------------------
`include "wavetable_resampling_oscillator_top_defines.svh"

module wro_dp #(
	parameter int TABLE_DEPTH = wro_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RING    = wro_pkg::MAX_RING_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wro_pkg::cmd_t                      cmd,
	output wro_pkg::stat_t                     stat,
	input  logic [wro_pkg::S_DATA_W-1:0]       s_tdata,
	input  logic                               cfg_we,
	input  logic [wro_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wro_pkg::CFG_W-1:0]          cfg_data,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [wro_pkg::SAMPLE_W-1:0]       m_tdata
);

	localparam int SW  = wro_pkg::SAMPLE_W;
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int MW  = $clog2(TABLE_DEPTH + 1);
	localparam int PW  = $clog2(MAX_RING);
	localparam int NW  = $clog2(MAX_RING + 1);
	localparam int RW  = PW + MW;
	localparam int DSW = NW + 1;
	localparam int QW  = (AW > SW) ? AW : SW;
	localparam int CW  = $clog2(QW + 1);
	localparam int PAW = NW + 17;
	localparam int PBW = NW + 18;
	localparam int TW  = NW + 20;

	logic [wro_pkg::RING_LEN_W-1:0]  ring_len_q;
	logic [wro_pkg::MODEL_LEN_W-1:0] model_len_q;
	logic [PW-1:0]                   pos_q;
	logic [RW-1:0]                   r_q;
	logic [AW-1:0]                   k_q;
	logic [NW-1:0]                   e_q;
	logic signed [SW-1:0]            a_q;
	logic signed [SW-1:0]            b_q;
	logic signed [PAW-1:0]           pa_q;
	logic signed [PBW-1:0]           pb_q;
	logic signed [TW-1:0]            t_q;
	logic                            out_valid_q;
	logic [SW-1:0]                   sample_q;

	logic [NW-1:0]        n;
	logic [MW-1:0]        m;
	logic [PW-1:0]        p_eff;
	logic [31:0]          p_inc;
	logic [PW-1:0]        p_next;
	logic [31:0]          k_inc;
	logic [AW-1:0]        k1;
	logic [AW-1:0]        k_div;
	logic signed [16:0]   diff;
	logic signed [TW-1:0] num;
	logic signed [TW-1:0] t_next;
	logic [TW-1:0]        mag;
	logic [SW-1:0]        q_mag;
	logic [SW-1:0]        sample_next;

	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [SW-1:0]  ram_rdata;

	logic           div_start;
	logic [CW-1:0]  div_iters;
	logic [DSW-1:0] div_rem_init;
	logic [QW-1:0]  div_lo_init;
	logic [DSW-1:0] div_divisor;
	logic           div_busy;
	logic [QW-1:0]  div_quo;
	logic [DSW-1:0] div_rem;

	// clamp the configured lengths to their legal ranges
	always_comb begin
		if (32'(ring_len_q) < 32'd2) begin
			n = NW'(2);
		end else if (32'(ring_len_q) > 32'(MAX_RING)) begin
			n = NW'(MAX_RING);
		end else begin
			n = NW'(ring_len_q);
		end
		if (32'(model_len_q) < 32'd2) begin
			m = MW'(2);
		end else if (32'(model_len_q) > 32'(TABLE_DEPTH)) begin
			m = MW'(TABLE_DEPTH);
		end else begin
			m = MW'(model_len_q);
		end
	end

	// position: restart when the ring shrank below it, wrap after advance
	assign p_eff  = (32'(pos_q) >= 32'(n)) ? '0 : pos_q;
	assign p_inc  = 32'(p_eff) + 32'd1;
	assign p_next = (p_inc >= 32'(n)) ? '0 : PW'(p_inc);

	assign k_div = (32'(div_quo[AW-1:0]) >= 32'(m)) ? AW'(32'(m) - 32'd1) : div_quo[AW-1:0];
	assign k_inc = 32'(k_q) + 32'd1;
	assign k1    = (k_inc >= 32'(m)) ? '0 : AW'(k_inc);

	assign diff   = 17'(b_q) - 17'(a_q);
	assign num    = TW'(pa_q) + TW'(pb_q);
	assign t_next = (num <<< 1) + $signed(TW'(n));
	assign mag    = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);

	// saturate the rounded quotient and restore its sign
	assign q_mag = div_quo[SW-1:0];
	always_comb begin
		if (!t_q[TW-1]) begin
			sample_next = (q_mag > wro_pkg::SAT_POS) ? wro_pkg::SAT_POS : q_mag;
		end else begin
			sample_next = (q_mag > wro_pkg::SAT_NEG_MAG) ? wro_pkg::SAT_NEG_MAG : SW'(-q_mag);
		end
	end

	// divider operands: index split, then the final rounding division
	assign div_start = cmd.div1_go || cmd.div2_go;
	always_comb begin
		if (cmd.div2_go) begin
			div_iters    = CW'(SW);
			div_rem_init = DSW'(mag >> SW);
			div_lo_init  = QW'(mag[SW-1:0]) << (QW - SW);
			div_divisor  = {n, 1'b0};
		end else begin
			div_iters    = CW'(AW);
			div_rem_init = DSW'(r_q >> AW);
			div_lo_init  = QW'(r_q[AW-1:0]) << (QW - AW);
			div_divisor  = DSW'(n);
		end
	end

	assign ram_we    = cmd.load && (32'(s_tdata[wro_pkg::LOAD_IDX_W-1:0]) < 32'(TABLE_DEPTH));
	assign ram_raddr = cmd.rd_b ? k1 : k_q;

	wro_ram #(
		.WIDTH (SW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(s_tdata[wro_pkg::LOAD_IDX_W-1:0])),
		.wdata (s_tdata[wro_pkg::LOAD_IDX_W +: SW]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wro_div #(
		.DSW (DSW),
		.QW  (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.iters    (div_iters),
		.rem_init (div_rem_init),
		.lo_init  (div_lo_init),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_len_q  <= wro_pkg::RING_LEN_RST;
			model_len_q <= wro_pkg::MODEL_LEN_RST;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wro_pkg::CFG_RING_LENGTH: begin
						ring_len_q <= cfg_data[wro_pkg::RING_LEN_W-1:0];
					end
					wro_pkg::CFG_MODEL_LENGTH: begin
						model_len_q <= cfg_data[wro_pkg::MODEL_LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.mul_r) begin
				pos_q <= p_next;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_r) begin
			r_q <= RW'(p_eff) * RW'(m);
		end
		if (cmd.k_cap) begin
			k_q <= k_div;
			e_q <= NW'(div_rem);
		end
		if (cmd.a_cap) begin
			a_q <= $signed(ram_rdata);
		end
		if (cmd.mul_a) begin
			b_q  <= $signed(ram_rdata);
			pa_q <= PAW'(a_q) * PAW'($signed({1'b0, n}));
		end
		if (cmd.mul_b) begin
			pb_q <= PBW'($signed({1'b0, e_q})) * PBW'(diff);
		end
		if (cmd.sum) begin
			t_q <= t_next;
		end
		if (cmd.out_load) begin
			sample_q <= sample_next;
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = sample_q;

	`WRO_ASSERT_NXT(a_pos_range, clk, arst_n, cmd.mul_r, 32'(pos_q) < 32'(n))
	`WRO_ASSERT_NXT(a_k_range, clk, arst_n, cmd.k_cap, 32'(k_q) < 32'(m))

endmodule

### rtl/wro_ctrl.sv
// ----------------------------------------------------------------------------
// wro_ctrl
// Sequencer for one tick: multiply, divide, two table reads, blend, round.
// ----------------------------------------------------------------------------
`include "wavetable_resampling_oscillator_top_defines.svh"

module wro_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            op,
	output logic            s_tready,
	input  wro_pkg::stat_t  stat,
	output wro_pkg::cmd_t   cmd
);

	wro_pkg::state_t state_q;
	wro_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wro_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wro_pkg::ST_IDLE: begin
				if (s_tvalid && op == wro_pkg::OP_TICK) begin
					state_d = wro_pkg::ST_MUL_R;
				end
			end
			wro_pkg::ST_MUL_R:   state_d = wro_pkg::ST_DIV1_GO;
			wro_pkg::ST_DIV1_GO: state_d = wro_pkg::ST_DIV1_WAIT;
			wro_pkg::ST_DIV1_WAIT: begin
				if (!stat.div_busy) begin
					state_d = wro_pkg::ST_RD_A;
				end
			end
			wro_pkg::ST_RD_A:    state_d = wro_pkg::ST_RD_B;
			wro_pkg::ST_RD_B:    state_d = wro_pkg::ST_MUL_A;
			wro_pkg::ST_MUL_A:   state_d = wro_pkg::ST_MUL_B;
			wro_pkg::ST_MUL_B:   state_d = wro_pkg::ST_SUM;
			wro_pkg::ST_SUM:     state_d = wro_pkg::ST_DIV2_GO;
			wro_pkg::ST_DIV2_GO: state_d = wro_pkg::ST_DIV2_WAIT;
			wro_pkg::ST_DIV2_WAIT: begin
				if (!stat.div_busy) begin
					state_d = wro_pkg::ST_DONE;
				end
			end
			wro_pkg::ST_DONE: begin
				if (stat.out_free) begin
					state_d = wro_pkg::ST_IDLE;
				end
			end
			default: state_d = wro_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			wro_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid && op == wro_pkg::OP_LOAD;
			end
			wro_pkg::ST_MUL_R:     cmd.mul_r = 1'b1;
			wro_pkg::ST_DIV1_GO:   cmd.div1_go = 1'b1;
			wro_pkg::ST_DIV1_WAIT: cmd.k_cap = !stat.div_busy;
			wro_pkg::ST_RD_A: begin
			end
			wro_pkg::ST_RD_B: begin
				cmd.rd_b  = 1'b1;
				cmd.a_cap = 1'b1;
			end
			wro_pkg::ST_MUL_A:   cmd.mul_a = 1'b1;
			wro_pkg::ST_MUL_B:   cmd.mul_b = 1'b1;
			wro_pkg::ST_SUM:     cmd.sum = 1'b1;
			wro_pkg::ST_DIV2_GO: cmd.div2_go = 1'b1;
			wro_pkg::ST_DIV2_WAIT: begin
			end
			wro_pkg::ST_DONE:    cmd.out_load = stat.out_free;
			default: begin
			end
		endcase
	end

	`WRO_ASSERT_NXT(a_tick_starts, clk, arst_n, s_tvalid && s_tready && op == wro_pkg::OP_TICK, state_q == wro_pkg::ST_MUL_R)
	`WRO_ASSERT_IMP(a_div_idle, clk, arst_n, cmd.div1_go || cmd.div2_go, !stat.div_busy)

endmodule

### rtl/wavetable_resampling_oscillator_top.sv
// ----------------------------------------------------------------------------
// wavetable_resampling_oscillator_top
// Wavetable oscillator: stored model period, linearly interpolated playback.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser selects the request kind. A load request writes
// one table entry, and loads stream at one per clock while no tick is being
// processed; an index beyond the table is dropped. A tick request produces
// one sample on the output stream (m_*) and advances the ring position,
// wrapping at the ring length.
// A tick runs the shared restoring divider twice, first splitting position
// times model length into table index and fraction (log2(TABLE_DEPTH)
// steps), then rounding the blended value (16 steps). The two table entries
// come from the one read port of the table RAM on consecutive cycles. The
// next request is taken only after the tick's sample is in the output
// register.
// A finished sample sits in the output register; the block takes new
// requests while it waits there, and only a second finished sample holds
// until m_tready drains the first.
// Reset returns the position to zero and the ring and model lengths to 200
// and 133; the table keeps its contents and holds garbage until loaded.
// Configuration writes (cfg_we) are registered; issue them while idle.
// ----------------------------------------------------------------------------
module wavetable_resampling_oscillator_top #(
	parameter int TABLE_DEPTH = wro_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RING    = wro_pkg::MAX_RING_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wro_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] load_index, [23:8] load_value
	input  logic                          s_tuser,   // [0] operation
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wro_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample
	// configuration write port
	input  logic                          cfg_we,
	input  logic [wro_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wro_pkg::CFG_W-1:0]     cfg_data
);

	wro_pkg::cmd_t  cmd;
	wro_pkg::stat_t stat;

	// sequence each request
	wro_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold table, position, arithmetic and the output register
	wro_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_RING    (MAX_RING)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### dv/tb_wavetable_resampling_oscillator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the wavetable resampling oscillator
// A walked table of directed requests and register writes comes first: the
// extreme samples, the clamped lengths, a position left past a shrunk ring,
// the round-half cases and the wrap of the last interval. Random phases with
// varying lengths, random stalls on both streams and one long output hold-off
// follow. Every tick is checked against a typed-in sample or an in-bench model of the sample math.
// ----------------------------------------------------------------------------
module tb_wavetable_resampling_oscillator_top;

	localparam int          NUM_PHASES      = 8;
	localparam int          ITEMS_PER_PHASE = 90;
	localparam int          PRESSURE_PHASE  = 2;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned SETTLE_CYCLES   = 48;     // above the tick latency
	localparam int unsigned LIMIT_CYCLES    = 1000000;
	localparam int          DIR_ROWS        = 24;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [wro_pkg::S_DATA_W-1:0]    s_tdata;   // [7:0] load_index, [23:8] load_value
	logic                            s_tuser;   // [0] operation
	logic                            m_tvalid;
	logic                            m_tready;
	logic [wro_pkg::SAMPLE_W-1:0]    m_tdata;   // [15:0] sample
	logic                            cfg_we;
	logic [wro_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [wro_pkg::CFG_W-1:0]       cfg_data;

	wavetable_resampling_oscillator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Directed rows: a register write or a stream request, with the sample
	// typed in where it is obvious; other ticks fall back on the predictor.
	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic          op;
		logic [7:0]    addr;    // load index or register index
		logic [15:0]   value;   // load value or register data
		logic          chk;
		logic [15:0]   want;
	} dir_row_t;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// after reset: ring 200, model 133; full-scale step between entries 0 and 1
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd0,   16'h7FFF, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd1,   16'h8000, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h7FFF},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b0, 16'h0000},
		// lengths below range clamp to 2; the position 2 is now past the ring
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_RING_LENGTH),  16'd0, 1'b0, 16'h0000},
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_MODEL_LENGTH), 16'd0, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h7FFF},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h8001},  // -32768 rounds up
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h7FFF},
		// lengths above range clamp to 1024 and 256
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_RING_LENGTH),  16'd2047, 1'b0, 16'h0000},
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_MODEL_LENGTH), 16'd511,  1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b0, 16'h0000},
		// ring 4, model 2, position 3: half-way points and the wrapping interval
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_RING_LENGTH),  16'd4, 1'b0, 16'h0000},
		'{ROW_CFG, wro_pkg::OP_LOAD, 8'(wro_pkg::CFG_MODEL_LENGTH), 16'd2, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd0,   16'h0000, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd1,   16'h0001, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h0001},  // 1 down to 0, +0.5 up
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h0001},  // 0.5 rounds to 1
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd1,   16'hFFFF, 1'b0, 16'h0000},
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h0000},  // -1 rounds to 0
		'{ROW_REQ, wro_pkg::OP_TICK, 8'd0,   16'h0000, 1'b1, 16'h0000},  // -0.5 rounds to 0
		'{ROW_REQ, wro_pkg::OP_LOAD, 8'd255, 16'h7FFF, 1'b0, 16'h0000}
	};

	// predictor state
	logic signed [wro_pkg::SAMPLE_W-1:0] shadow_table [wro_pkg::TABLE_DEPTH_DEF];
	bit                                  table_loaded [wro_pkg::TABLE_DEPTH_DEF];
	logic [wro_pkg::RING_LEN_W-1:0]      shadow_ring;
	logic [wro_pkg::MODEL_LEN_W-1:0]     shadow_model;
	int unsigned                         ring_pos;

	logic [wro_pkg::SAMPLE_W-1:0]        pending_samples [$];
	logic [wro_pkg::SAMPLE_W-1:0]        expected_sample;
	int unsigned                         error_count;
	int unsigned                         cycle_count;
	bit                                  tx_pace;
	bit                                  rx_pace;
	bit                                  long_hold_req;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int unsigned ring_len_eff();
		if (shadow_ring < 2)
			return 2;
		if (shadow_ring > wro_pkg::MAX_RING_DEF)
			return wro_pkg::MAX_RING_DEF;
		return shadow_ring;
	endfunction

	function automatic int unsigned model_len_eff();
		if (shadow_model < 2)
			return 2;
		if (shadow_model > wro_pkg::TABLE_DEPTH_DEF)
			return wro_pkg::TABLE_DEPTH_DEF;
		return shadow_model;
	endfunction

	// Map the current position onto the two table entries and the fraction.
	function automatic void locate_entries(output int unsigned k, output int unsigned k1,
					       output int unsigned frac);
		int unsigned n;
		int unsigned m;
		int unsigned p;
		longint unsigned r;
		n = ring_len_eff();
		m = model_len_eff();
		p = (ring_pos >= n) ? 0 : ring_pos;
		r = longint'(p) * m;
		k = r / n;
		frac = r % n;
		if (k >= m)
			k = m - 1;
		k1 = (k + 1 >= m) ? 0 : k + 1;
	endfunction

	// Blend the two entries, round by adding one half and truncating toward zero, advance.
	function automatic logic [wro_pkg::SAMPLE_W-1:0] predict_sample();
		int unsigned n;
		int unsigned k;
		int unsigned k1;
		int unsigned frac;
		int unsigned p;
		longint a;
		longint b;
		longint num;
		longint q;
		n = ring_len_eff();
		locate_entries(k, k1, frac);
		a = longint'(shadow_table[k]);
		b = longint'(shadow_table[k1]);
		num = a * longint'(n) + longint'(frac) * (b - a);
		q = (2 * num + longint'(n)) / (2 * longint'(n));
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		p = (ring_pos >= n) ? 0 : ring_pos;
		ring_pos = (p + 1 >= n) ? 0 : p + 1;
		return q[wro_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic int unsigned pick_gap(input bit pace);
		int unsigned r;
		if (!pace)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] random_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Offer one request, hold it until accepted, then update the predictor.
	task automatic send_request(input logic op, input logic [7:0] idx,
				    input logic [15:0] val, input logic chk,
				    input logic [15:0] want);
		logic [wro_pkg::SAMPLE_W-1:0] predicted;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == wro_pkg::OP_TICK) begin
			predicted = predict_sample();
			pending_samples.push_back(chk ? want : predicted);
		end else begin
			shadow_table[idx] = val;
			table_loaded[idx] = 1'b1;
		end
	endtask

	task automatic idle_gap(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
	endtask

	// Drop valid, drain every pending sample, then let a tick's latency pass.
	task automatic settle_block();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [wro_pkg::CFG_IDX_W-1:0] idx,
				      input logic [wro_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == wro_pkg::CFG_RING_LENGTH)
			shadow_ring = data;
		else
			shadow_model = data[wro_pkg::MODEL_LEN_W-1:0];
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				stall_left = HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (rx_pace && $urandom_range(0, 3) == 0)
					stall_left = pick_gap(1'b1);
			end
		end
	end

	// Compare every accepted sample with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("sample %0d with nothing expected",
					$signed(m_tdata)));
			end else begin
				expected_sample = pending_samples.pop_front();
				if (m_tdata !== expected_sample)
					report_mismatch($sformatf("sample %0d, expected %0d",
						$signed(m_tdata), $signed(expected_sample)));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_wavetable_resampling_oscillator_top: done, errors");
		$finish;
	end

	initial begin
		int unsigned row;
		int unsigned phase;
		int unsigned i;
		int unsigned k;
		int unsigned k1;
		int unsigned frac;
		logic [wro_pkg::CFG_W-1:0] ring_val;
		logic [wro_pkg::CFG_W-1:0] model_val;
		logic [wro_pkg::S_DATA_W-1:0] noise;

		s_tvalid      = 1'b0;
		s_tuser       = wro_pkg::OP_LOAD;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = wro_pkg::CFG_RING_LENGTH;
		cfg_data      = '0;
		error_count   = 0;
		tx_pace       = 1'b1;
		rx_pace       = 1'b1;
		long_hold_req = 1'b0;
		shadow_ring   = wro_pkg::RING_LEN_RST;
		shadow_model  = wro_pkg::MODEL_LEN_RST;
		ring_pos      = 0;
		for (i = 0; i < wro_pkg::TABLE_DEPTH_DEF; i++) begin
			shadow_table[i] = '0;
			table_loaded[i] = 1'b0;
		end

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_rows[row].kind == ROW_CFG) begin
				settle_block();
				write_register(dir_rows[row].addr[wro_pkg::CFG_IDX_W-1:0],
					dir_rows[row].value[wro_pkg::CFG_W-1:0]);
			end else begin
				send_request(dir_rows[row].op, dir_rows[row].addr, dir_rows[row].value,
					dir_rows[row].chk, dir_rows[row].want);
				idle_gap(pick_gap(1'b1));
			end
		end

		// random phases: extremes first, then random lengths
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle_block();
			case (phase)
				0: begin ring_val = 11'd1024; model_val = 11'd256; end
				1: begin ring_val = 11'd2;    model_val = 11'd2;   end
				2: begin ring_val = 11'd2047; model_val = 11'd511; end
				3: begin ring_val = 11'd0;    model_val = 11'd1;   end
				default: begin
					ring_val = ($urandom_range(0, 3) == 0) ?
						11'($urandom_range(0, 2047)) : 11'($urandom_range(2, 64));
					model_val = {2'($urandom_range(0, 3)),
						($urandom_range(0, 3) == 0) ?
						9'($urandom_range(0, 511)) : 9'($urandom_range(2, 40))};
				end
			endcase
			write_register(wro_pkg::CFG_RING_LENGTH, ring_val);
			write_register(wro_pkg::CFG_MODEL_LENGTH, model_val);

			// phase 1 runs with no idling at all; the pressure phase keeps
			// the input busy while the output holds off
			tx_pace = (phase == 1 || phase == PRESSURE_PHASE) ? 1'b0 :
				($urandom_range(0, 3) != 0);
			rx_pace = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (phase == PRESSURE_PHASE)
				long_hold_req = 1'b1;

			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) < 55) begin
					// load the entries the tick will read, if they are not loaded yet
					locate_entries(k, k1, frac);
					if (!table_loaded[k]) begin
						send_request(wro_pkg::OP_LOAD, 8'(k), random_value(), 1'b0, '0);
						idle_gap(pick_gap(tx_pace));
					end
					if (!table_loaded[k1]) begin
						send_request(wro_pkg::OP_LOAD, 8'(k1), random_value(), 1'b0, '0);
						idle_gap(pick_gap(tx_pace));
					end
					noise = wro_pkg::S_DATA_W'($urandom);
					send_request(wro_pkg::OP_TICK, noise[7:0], noise[23:8], 1'b0, '0);
				end else if ($urandom_range(0, 3) != 0) begin
					send_request(wro_pkg::OP_LOAD,
						8'($urandom_range(0, model_len_eff() - 1)),
						random_value(), 1'b0, '0);
				end else begin
					send_request(wro_pkg::OP_LOAD, 8'($urandom_range(0, 255)),
						random_value(), 1'b0, '0);
				end
				idle_gap(pick_gap(tx_pace));
			end
		end

		settle_block();
		if (error_count == 0)
			$display("tb_wavetable_resampling_oscillator_top: done, clean");
		else
			$display("tb_wavetable_resampling_oscillator_top: done, errors");
		$finish;
	end

endmodule
